// ===== rtl/core/vofd_pkg.sv =====
`default_nettype none

package vofd_pkg;

  // Default sizes handed to the top level
  localparam int HISTORY_DEPTH_DEF = 32;
  localparam int CHANNELS_DEF      = 4;

  // Fixed-point constants
  localparam logic [40:0]        W_ONE        = 41'd16777216;        // 1.0 in Q.24
  localparam logic [40:0]        W_CAP        = 41'h0FF_FFFF_FFFF;   // 2^40-1
  localparam logic [61:0]        MAG_CAP      = {62{1'b1}};          // 2^62-1
  localparam logic [30:0]        ONE_Q30      = 31'd1073741824;
  localparam logic [29:0]        LN2_Q30      = 30'd744261118;
  localparam int                 EXP_TERMS    = 12;
  localparam logic signed [31:0] LOG2TS_RESET = -32'sd167198110;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_NEXT,
    S_READ,
    S_CHECK,
    S_W_MUL,
    S_W_DLD,
    S_W_DIV,
    S_W_UPD,
    S_D_MUL,
    S_SPLIT,
    S_T_MUL,
    S_T_SET,
    S_R_MUL,
    S_R_DLD,
    S_R_DIV,
    S_R_UPD,
    S_C_MUL,
    S_C_SET,
    S_Y_MUL,
    S_SHIFT,
    S_ACC,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/variable_order_fractional_difference.sv =====
`default_nettype none

// Variable-order Grunwald-Letnikov fractional difference. Each input transaction
// carries a channel, a Q16.16 sample and a Q4.12 order; the block returns one
// Q16.16 result for the same channel, saturated to 32 bits, computed as the sample
// scaled by Ts^-a minus the weighted, Ts-scaled sum of that channel's past results
// (a ring of HISTORY_DEPTH results and orders per channel). A transaction whose
// channel is not below CHANNELS is consumed and produces nothing. cfg_wr_data sets
// log2(Ts) in signed Q8.24 and must only be written while the block is idle.
// All work runs through one 32x32 multiplier (two passes per product) and one
// radix-2 divider under a sequencer, so the block takes a single transaction at a
// time. The sample term is skipped for a zero sample. For every stored nonzero
// history entry at lag j, the weight is built in up to j steps, each a multiply
// and a divide, then scaled through an exponential series of twelve terms.
// Entries never written and zero results are skipped. Histories start empty at
// reset through a per-channel write position and wrap flag, so no clearing pass is needed.
module variable_order_fractional_difference #(
  parameter int HISTORY_DEPTH = vofd_pkg::HISTORY_DEPTH_DEF,
  parameter int CHANNELS      = vofd_pkg::CHANNELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_wr_en,
  input  wire logic signed [31:0] cfg_wr_data,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [1:0]  in_channel,
  input  wire logic signed [31:0] in_sample_value,
  input  wire logic signed [15:0] in_order,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [1:0]  out_result_channel,
  output logic signed      [31:0] out_result_value
);

  localparam int IDX_W   = $clog2(HISTORY_DEPTH);
  localparam int KW      = (IDX_W > 4) ? IDX_W : 4;
  localparam int USED_CH = (CHANNELS < 4) ? CHANNELS : 4;
  localparam int CH_AW   = (USED_CH > 1) ? $clog2(USED_CH) : 1;
  localparam int CH_N    = 2 ** CH_AW;
  localparam int AW      = CH_AW + IDX_W;
  localparam int MEM_N   = 2 ** AW;

  // Q.24 shift-cap helper: floor(p * 2^-s), clamped at MAG_CAP
  function automatic logic [61:0] shift_cap(input logic [72:0] p,
                                            input logic signed [14:0] s);
    logic [72:0] v;
    logic [6:0]  m;
    logic [61:0] res;
    v   = '0;
    m   = '0;
    res = '0;
    if (s >= 15'sd73) begin
      res = '0;
    end else if (s >= 15'sd0) begin
      v   = p >> s[6:0];
      res = (v[72:62] != '0) ? vofd_pkg::MAG_CAP : v[61:0];
    end else if (s <= -15'sd63) begin
      res = (p != '0) ? vofd_pkg::MAG_CAP : '0;
    end else begin
      m = 7'(-s);
      v = p >> (7'd62 - m);
      res = (v != '0) ? vofd_pkg::MAG_CAP : 62'(p << m);
    end
    return res;
  endfunction

  vofd_pkg::state_t state_r, state_nxt;

  // configuration and per-channel ring control
  logic signed [31:0] lg_r;
  logic [IDX_W-1:0]   pos_r  [CH_N];
  logic               wrap_r [CH_N];

  // transaction context
  logic [1:0]         ch_r, ch_nxt;
  logic signed [15:0] a_r, a_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [KW-1:0]      k_r, k_nxt;

  // term operands
  logic signed [15:0] aj_r, aj_nxt;
  logic [31:0]        ymag_r, ymag_nxt;
  logic               yneg_r, yneg_nxt;
  logic [40:0]        wmag_r, wmag_nxt;
  logic               wneg_r, wneg_nxt;
  logic [40:0]        cmag_r, cmag_nxt;
  logic signed [16:0] d_r, d_nxt;
  logic               add_r, add_nxt;

  // shared multiplier
  logic               mp_r, mp_nxt;
  logic [72:0]        prod_r, prod_nxt;
  logic [40:0]        mul_a;
  logic [31:0]        mul_b;
  logic [31:0]        mul_part;
  logic [63:0]        pp;
  logic               mul_active;

  // power-of-two path
  logic [23:0]        f_r, f_nxt;
  logic signed [14:0] s_r, s_nxt;
  logic [29:0]        t_r, t_nxt;
  logic [30:0]        r_r, r_nxt;
  logic [61:0]        mag_r, mag_nxt;

  // shared divider
  logic [48:0]        dq_r, dq_nxt;
  logic [KW-1:0]      drem_r, drem_nxt;
  logic [5:0]         dcnt_r, dcnt_nxt;
  logic [KW:0]        drem2;
  logic               dge;
  logic               div_last;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_ch_r, out_ch_nxt;
  logic signed [31:0] out_val_r, out_val_nxt;

  // history memory: {result, order}
  logic [47:0]        mem [MEM_N];
  logic [47:0]        rd_r;

  // helpers
  logic [CH_AW-1:0]   chi;
  logic [IDX_W-1:0]   cur_pos;
  logic [IDX_W-1:0]   pos_inc;
  logic [IDX_W-1:0]   jn;
  logic [IDX_W:0]     idx_sum;
  logic               ch_ok;
  logic               hist_valid;
  logic signed [31:0] rd_y;
  logic signed [21:0] num_s;
  logic [20:0]        num_mag;
  logic               num_neg;
  logic [16:0]        dmag;
  logic [31:0]        lg_mag;
  logic [49:0]        psg;
  logic signed [13:0] n_s;
  logic [40:0]        qsat;
  logic               k_eq_j;
  logic signed [64:0] sum;
  logic signed [64:0] cap_s;
  logic signed [31:0] res32;
  logic               fin_go;

  assign chi      = ch_r[CH_AW-1:0];
  assign cur_pos  = pos_r[chi];
  assign pos_inc  = (cur_pos == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : cur_pos + 1'b1;
  assign jn       = j_r + 1'b1;
  assign idx_sum  = {1'b0, cur_pos} + (IDX_W + 1)'(HISTORY_DEPTH) - {1'b0, jn};
  assign ch_ok    = ({30'd0, in_channel} < 32'(CHANNELS));
  assign hist_valid = wrap_r[chi] || (idx_r < cur_pos);
  assign rd_y     = $signed(rd_r[47:16]);

  // weight step numerator (1-k)*4096 - a
  assign num_s    = (($signed(22'(k_r)) * -22'sd1 + 22'sd1) <<< 12) - 22'(aj_r);
  assign num_neg  = num_s[21];
  assign num_mag  = num_neg ? 21'(-num_s) : 21'(num_s);

  assign dmag     = d_r[16] ? 17'(-d_r) : 17'(d_r);
  assign lg_mag   = lg_r[31] ? 32'(-lg_r) : 32'(lg_r);
  assign psg      = (d_r[16] ^ lg_r[31]) ? 50'(-{2'b00, prod_r[47:0]})
                                         : {2'b00, prod_r[47:0]};
  assign n_s      = $signed(psg[49:36]);

  assign qsat     = (dq_r > 49'(vofd_pkg::W_CAP)) ? vofd_pkg::W_CAP : dq_r[40:0];
  assign k_eq_j   = (k_r == KW'(j_r));

  // divider step
  assign drem2    = {drem_r, dq_r[48]};
  assign dge      = (drem2 >= {1'b0, k_r});
  assign div_last = (dcnt_r == 6'd1);

  // accumulate with saturation
  assign cap_s    = $signed({3'b000, vofd_pkg::MAG_CAP});
  assign sum      = add_r ? 65'(acc_r) + $signed({3'b000, mag_r})
                          : 65'(acc_r) - $signed({3'b000, mag_r});

  assign res32    = (acc_r > 64'sd2147483647)  ? 32'sh7FFF_FFFF :
                    (acc_r < -64'sd2147483648) ? 32'sh8000_0000 : acc_r[31:0];

  assign fin_go   = (state_r == vofd_pkg::S_FIN) && (!out_valid_r || !out_stall);

  // shared multiplier: 41x32 as two 32x32 passes
  always_comb begin
    mul_active = 1'b1;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_r)
      vofd_pkg::S_W_MUL: begin
        mul_a = wmag_r;
        mul_b = {11'd0, num_mag};
      end
      vofd_pkg::S_D_MUL: begin
        mul_a = {24'd0, dmag};
        mul_b = lg_mag;
      end
      vofd_pkg::S_T_MUL: begin
        mul_a = {17'd0, f_r};
        mul_b = {2'd0, vofd_pkg::LN2_Q30};
      end
      vofd_pkg::S_R_MUL: begin
        mul_a = {10'd0, r_r};
        mul_b = {2'd0, t_r};
      end
      vofd_pkg::S_C_MUL: begin
        mul_a = cmag_r;
        mul_b = {1'b0, r_r};
      end
      vofd_pkg::S_Y_MUL: begin
        mul_a = cmag_r;
        mul_b = ymag_r;
      end
      default: mul_active = 1'b0;
    endcase
  end

  assign mul_part = mp_r ? {23'd0, mul_a[40:32]} : mul_a[31:0];
  assign pp       = mul_part * mul_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vofd_pkg::S_IDLE: begin
        if (in_valid && ch_ok) begin
          state_nxt = (in_sample_value == '0) ? vofd_pkg::S_NEXT : vofd_pkg::S_D_MUL;
        end
      end
      vofd_pkg::S_NEXT: begin
        state_nxt = (j_r == IDX_W'(HISTORY_DEPTH - 1)) ? vofd_pkg::S_FIN
                                                       : vofd_pkg::S_READ;
      end
      vofd_pkg::S_READ:  state_nxt = vofd_pkg::S_CHECK;
      vofd_pkg::S_CHECK: begin
        state_nxt = (hist_valid && rd_y != '0) ? vofd_pkg::S_W_MUL : vofd_pkg::S_NEXT;
      end
      vofd_pkg::S_W_MUL: if (mp_r) state_nxt = vofd_pkg::S_W_DLD;
      vofd_pkg::S_W_DLD: state_nxt = vofd_pkg::S_W_DIV;
      vofd_pkg::S_W_DIV: if (div_last) state_nxt = vofd_pkg::S_W_UPD;
      vofd_pkg::S_W_UPD: begin
        if (qsat == '0) begin
          state_nxt = vofd_pkg::S_NEXT;
        end else if (k_eq_j) begin
          state_nxt = vofd_pkg::S_D_MUL;
        end else begin
          state_nxt = vofd_pkg::S_W_MUL;
        end
      end
      vofd_pkg::S_D_MUL: if (mp_r) state_nxt = vofd_pkg::S_SPLIT;
      vofd_pkg::S_SPLIT: state_nxt = vofd_pkg::S_T_MUL;
      vofd_pkg::S_T_MUL: if (mp_r) state_nxt = vofd_pkg::S_T_SET;
      vofd_pkg::S_T_SET: state_nxt = vofd_pkg::S_R_MUL;
      vofd_pkg::S_R_MUL: if (mp_r) state_nxt = vofd_pkg::S_R_DLD;
      vofd_pkg::S_R_DLD: state_nxt = vofd_pkg::S_R_DIV;
      vofd_pkg::S_R_DIV: if (div_last) state_nxt = vofd_pkg::S_R_UPD;
      vofd_pkg::S_R_UPD: begin
        state_nxt = (k_r == KW'(1)) ? vofd_pkg::S_C_MUL : vofd_pkg::S_R_MUL;
      end
      vofd_pkg::S_C_MUL: if (mp_r) state_nxt = vofd_pkg::S_C_SET;
      vofd_pkg::S_C_SET: state_nxt = vofd_pkg::S_Y_MUL;
      vofd_pkg::S_Y_MUL: if (mp_r) state_nxt = vofd_pkg::S_SHIFT;
      vofd_pkg::S_SHIFT: state_nxt = vofd_pkg::S_ACC;
      vofd_pkg::S_ACC:   state_nxt = vofd_pkg::S_NEXT;
      vofd_pkg::S_FIN:   if (fin_go) state_nxt = vofd_pkg::S_IDLE;
      default:           state_nxt = vofd_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    ch_nxt   = ch_r;
    a_nxt    = a_r;
    acc_nxt  = acc_r;
    j_nxt    = j_r;
    idx_nxt  = idx_r;
    k_nxt    = k_r;
    aj_nxt   = aj_r;
    ymag_nxt = ymag_r;
    yneg_nxt = yneg_r;
    wmag_nxt = wmag_r;
    wneg_nxt = wneg_r;
    cmag_nxt = cmag_r;
    d_nxt    = d_r;
    add_nxt  = add_r;
    f_nxt    = f_r;
    s_nxt    = s_r;
    t_nxt    = t_r;
    r_nxt    = r_r;
    mag_nxt  = mag_r;
    dq_nxt   = dq_r;
    drem_nxt = drem_r;
    dcnt_nxt = dcnt_r;
    mp_nxt   = 1'b0;
    prod_nxt = prod_r;

    if (mul_active) begin
      mp_nxt   = !mp_r;
      prod_nxt = mp_r ? prod_r + {pp[40:0], 32'd0} : 73'(pp);
    end

    unique case (state_r)
      vofd_pkg::S_IDLE: begin
        // latch the transaction and set up the sample term
        ch_nxt   = in_channel;
        a_nxt    = in_order;
        acc_nxt  = '0;
        j_nxt    = '0;
        cmag_nxt = vofd_pkg::W_ONE;
        ymag_nxt = in_sample_value[31] ? 32'(-in_sample_value) : 32'(in_sample_value);
        d_nxt    = -(17'(in_order));
        add_nxt  = !in_sample_value[31];
      end
      vofd_pkg::S_NEXT: begin
        j_nxt   = jn;
        idx_nxt = (cur_pos >= jn) ? cur_pos - jn : idx_sum[IDX_W-1:0];
      end
      vofd_pkg::S_CHECK: begin
        aj_nxt   = $signed(rd_r[15:0]);
        ymag_nxt = rd_y[31] ? 32'(-rd_y) : 32'(rd_y);
        yneg_nxt = rd_y[31];
        wmag_nxt = vofd_pkg::W_ONE;
        wneg_nxt = 1'b0;
        k_nxt    = KW'(1);
      end
      vofd_pkg::S_W_DLD: begin
        dq_nxt   = prod_r[60:12];
        drem_nxt = '0;
        dcnt_nxt = 6'd49;
      end
      vofd_pkg::S_W_DIV, vofd_pkg::S_R_DIV: begin
        dq_nxt   = {dq_r[47:0], dge};
        drem_nxt = dge ? KW'(drem2 - {1'b0, k_r}) : KW'(drem2);
        dcnt_nxt = dcnt_r - 6'd1;
      end
      vofd_pkg::S_W_UPD: begin
        wmag_nxt = qsat;
        wneg_nxt = wneg_r ^ num_neg;
        k_nxt    = k_r + 1'b1;
        // last weight step: hand the term to the power path
        cmag_nxt = qsat;
        d_nxt    = 17'(aj_r) - 17'(a_r);
        add_nxt  = j_r[0] ^ wneg_r ^ num_neg ^ yneg_r;
      end
      vofd_pkg::S_SPLIT: begin
        f_nxt = psg[35:12];
        s_nxt = 15'sd24 - 15'(n_s);
      end
      vofd_pkg::S_T_SET: begin
        t_nxt = prod_r[53:24];
        r_nxt = vofd_pkg::ONE_Q30;
        k_nxt = KW'(vofd_pkg::EXP_TERMS);
      end
      vofd_pkg::S_R_DLD: begin
        dq_nxt   = {prod_r[60:30], 18'd0};
        drem_nxt = '0;
        dcnt_nxt = 6'd31;
      end
      vofd_pkg::S_R_UPD: begin
        r_nxt = vofd_pkg::ONE_Q30 + dq_r[30:0];
        k_nxt = k_r - 1'b1;
      end
      vofd_pkg::S_C_SET: cmag_nxt = prod_r[70:30];
      vofd_pkg::S_SHIFT: mag_nxt = shift_cap(prod_r, s_r);
      vofd_pkg::S_ACC: begin
        if (sum > cap_s) begin
          acc_nxt = 64'(cap_s);
        end else if (sum < -cap_s) begin
          acc_nxt = 64'(-cap_s);
        end else begin
          acc_nxt = sum[63:0];
        end
      end
      default: begin
      end
    endcase
  end

  // result register: drop on take, load when the sequencer finishes
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_ch_nxt    = out_ch_r;
    out_val_nxt   = out_val_r;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
      out_ch_nxt    = ch_r;
      out_val_nxt   = res32;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vofd_pkg::S_IDLE;
      lg_r        <= vofd_pkg::LOG2TS_RESET;
      mp_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CH_N; c++) begin
        pos_r[c]  <= '0;
        wrap_r[c] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      mp_r        <= mp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        lg_r <= cfg_wr_data;
      end
      // advance the ring of this channel
      if (fin_go) begin
        pos_r[chi] <= pos_inc;
        if (cur_pos == IDX_W'(HISTORY_DEPTH - 1)) begin
          wrap_r[chi] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r      <= ch_nxt;
    a_r       <= a_nxt;
    acc_r     <= acc_nxt;
    j_r       <= j_nxt;
    idx_r     <= idx_nxt;
    k_r       <= k_nxt;
    aj_r      <= aj_nxt;
    ymag_r    <= ymag_nxt;
    yneg_r    <= yneg_nxt;
    wmag_r    <= wmag_nxt;
    wneg_r    <= wneg_nxt;
    cmag_r    <= cmag_nxt;
    d_r       <= d_nxt;
    add_r     <= add_nxt;
    prod_r    <= prod_nxt;
    f_r       <= f_nxt;
    s_r       <= s_nxt;
    t_r       <= t_nxt;
    r_r       <= r_nxt;
    mag_r     <= mag_nxt;
    dq_r      <= dq_nxt;
    drem_r    <= drem_nxt;
    dcnt_r    <= dcnt_nxt;
    out_ch_r  <= out_ch_nxt;
    out_val_r <= out_val_nxt;
  end

  // history memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (fin_go) begin
      mem[{chi, cur_pos}] <= {res32, a_r};
    end
    rd_r <= mem[{chi, idx_r}];
  end

  assign in_stall           = (state_r != vofd_pkg::S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_result_channel = out_ch_r;
  assign out_result_value   = out_val_r;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = 32;
  localparam int NCH = 4;
  localparam longint unsigned MAG_LIMIT = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam longint WEIGHT_ONE = 64'sd16777216;
  localparam longint WEIGHT_LIMIT = 64'sd1099511627775;
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned Q30_LN2 = 64'd744261118;
  localparam int RANDOM_PER_PHASE = 170;
  localparam int NPHASES = 6;
  // Heavy history makes one transaction long; the watchdog limit allows for that.
  localparam longint CYCLE_LIMIT = 200_000_000;

  typedef struct {
    logic [1:0]         ch;
    logic signed [31:0] sample;
    logic signed [15:0] ord;
  } sample_item_t;

  typedef struct {
    logic [1:0]         ch;
    logic signed [31:0] value;
  } diff_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic signed [31:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_channel = '0;
  logic signed [31:0] in_sample_value = '0;
  logic signed [15:0] in_order = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_result_channel;
  logic signed [31:0] out_result_value;

  variable_order_fractional_difference dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_channel(in_channel),
    .in_sample_value(in_sample_value), .in_order(in_order),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_channel(out_result_channel), .out_result_value(out_result_value)
  );

  always #5 clk = ~clk;

  // Shadow of the block's state: period setting and per-channel rings.
  longint log2_period = longint'(vofd_pkg::LOG2TS_RESET);
  longint past_y [NCH][DEPTH];
  longint past_a [NCH][DEPTH];
  int     ring_pos [NCH];

  sample_item_t pending_samples[$];
  diff_result_t expected_diffs[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int checked_count = 0;
  longint cycle_count = 0;

  initial begin
    foreach (past_y[c, i]) begin
      past_y[c][i] = 0;
      past_a[c][i] = 0;
    end
    foreach (ring_pos[c]) ring_pos[c] = 0;
  end

  // 2^f for f in [0,1) (Q.24), Q2.30 result, truncated Taylor series of exp.
  function automatic longint unsigned pow2_frac(longint unsigned f);
    longint unsigned t, r;
    t = (f * Q30_LN2) >> 24;
    r = Q30_ONE;
    for (int k = 12; k >= 1; k--) r = Q30_ONE + ((r * t) >> 30) / k;
    return r;
  endfunction

  // floor(p / 2^s), s may be negative, clamped to the magnitude cap
  function automatic longint unsigned clamp_shift(logic [127:0] p, longint s);
    logic [127:0] v;
    if (p == 0 || s >= 128) return 0;
    if (s >= 0) begin
      v = p >> s;
    end else begin
      if (p[127:64] != 0 || -s >= 63) return MAG_LIMIT;
      v = p << (-s);
    end
    return (v > MAG_LIMIT) ? MAG_LIMIT : v[63:0];
  endfunction

  // coef/2^24 * y * Ts^d, Q16.16 magnitude
  function automatic longint unsigned term_mag(longint unsigned coef, longint unsigned ymag,
                                               longint d, longint lg);
    longint e24, n;
    longint unsigned mant, t1;
    if (coef == 0 || ymag == 0) return 0;
    e24 = (d * lg) >>> 12;
    n = e24 >>> 24;
    mant = pow2_frac(longint'(e24 - (n <<< 24)));
    t1 = clamp_shift({64'd0, coef} * {64'd0, mant}, 30);
    return clamp_shift({64'd0, t1} * {64'd0, ymag}, 24 - n);
  endfunction

  function automatic longint gl_weight(int j, longint a);
    longint w;
    w = WEIGHT_ONE;
    for (longint k = 1; k <= j; k++) begin
      w = (w * ((1 - k) * 4096 - a)) / (k * 4096);
      if (w > WEIGHT_LIMIT) w = WEIGHT_LIMIT;
      if (w < -WEIGHT_LIMIT) w = -WEIGHT_LIMIT;
      if (w == 0) break;
    end
    return w;
  endfunction

  function automatic longint sat_accumulate(longint acc, longint unsigned mag, bit add);
    acc = add ? acc + longint'(mag) : acc - longint'(mag);
    if (acc > longint'(MAG_LIMIT)) acc = longint'(MAG_LIMIT);
    if (acc < -longint'(MAG_LIMIT)) acc = -longint'(MAG_LIMIT);
    return acc;
  endfunction

  // Compute the new difference value and advance the channel's ring.
  function automatic diff_result_t gl_difference(sample_item_t it);
    diff_result_t r;
    longint x, a, acc, y, aj, w;
    int pos, idx;
    bit neg;
    x = it.sample;
    a = it.ord;
    pos = ring_pos[it.ch];
    past_a[it.ch][pos] = a;
    acc = sat_accumulate(0, term_mag(WEIGHT_ONE, (x < 0) ? -x : x, -a, log2_period), x >= 0);
    for (int j = 1; j < DEPTH; j++) begin
      idx = (pos + DEPTH - j) % DEPTH;
      y = past_y[it.ch][idx];
      aj = past_a[it.ch][idx];
      if (y == 0) continue;
      w = gl_weight(j, aj);
      if (w == 0) continue;
      neg = (j % 2 == 1) ^ (w < 0) ^ (y < 0);
      acc = sat_accumulate(acc, term_mag((w < 0) ? -w : w, (y < 0) ? -y : y,
                                         aj - a, log2_period), neg);
    end
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    past_y[it.ch][pos] = acc;
    ring_pos[it.ch] = (pos + 1) % DEPTH;
    r.ch = it.ch;
    r.value = acc[31:0];
    return r;
  endfunction

  // Driver: predict on acceptance, then present the next pending transaction
  // or idle. A stalled payload is held untouched.
  always @(posedge clk) begin
    sample_item_t nxt;
    if (rst_n && (!in_valid || !in_stall)) begin
      if (in_valid)
        expected_diffs.push_back(gl_difference(
            sample_item_t'{in_channel, in_sample_value, in_order}));
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_samples.pop_front();
        in_valid <= 1'b1;
        in_channel <= nxt.ch;
        in_sample_value <= nxt.sample;
        in_order <= nxt.ord;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result against the oldest expectation.
  always @(posedge clk) begin
    diff_result_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_diffs.size() == 0) begin
          $error("unexpected result: channel %0d value %0d",
                 out_result_channel, out_result_value);
          fail_count++;
        end else begin
          exp_r = expected_diffs.pop_front();
          checked_count++;
          if (out_result_channel !== exp_r.ch) begin
            $error("result_channel: expected %0d actual %0d", exp_r.ch, out_result_channel);
            fail_count++;
          end
          if (out_result_value !== exp_r.value) begin
            $error("result_value: expected %0d actual %0d", exp_r.value, out_result_value);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_diffs.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_sample();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return $signed($urandom_range(262143)) - 32'sd131072;
    if (sel < 6) begin
      case ($urandom_range(3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // Mostly order zero: its weights vanish at once, which keeps the history
  // walk cheap; the rest exercise integer, small and full-range orders.
  function automatic logic signed [15:0] pick_order();
    int sel;
    sel = $urandom_range(99);
    if (sel < 74) return 16'sd0;
    if (sel < 80) return 16'(($signed($urandom_range(6)) - 3) * 4096);
    if (sel < 92) return 16'($signed($urandom_range(8191)) - 4096);
    return 16'($urandom);
  endfunction

  // Hold until nothing is queued, in flight or waiting at the output.
  // Sample at the falling edge so that every update of the rising edge has settled.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_samples.size() != 0 || expected_diffs.size() != 0 || in_valid || in_stall);
  endtask

  // Wait for the block to drain, set the period, then queue stimulus for one phase.
  task automatic run_phase(input int idx, input logic signed [31:0] period);
    sample_item_t it;
    logic signed [31:0] dir_samples [7];
    logic signed [15:0] dir_orders [7];
    // wait for quiet before touching the register
    wait_quiet();
    repeat (20) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= period;
    log2_period = period;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
      default: begin send_idle_pct = 9; recv_stall_pct = 9; end
    endcase
    if (idx == 0) begin
      // directed: field extremes on every channel, integer and tiny orders
      dir_samples = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                      32'sd65536, -32'sd65536};
      dir_orders = '{16'sd0, 16'sh7FFF, 16'sh8000, 16'sd4096, -16'sd4096, 16'sd2048, 16'sd1};
      for (int i = 0; i < 21; i++) begin
        it.ch = 2'(i % NCH);
        it.sample = dir_samples[i % 7];
        it.ord = dir_orders[(i / 3) % 7];
        pending_samples.push_back(it);
      end
    end
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      it.ch = 2'($urandom_range(NCH - 1));
      it.sample = pick_sample();
      it.ord = pick_order();
      pending_samples.push_back(it);
    end
  endtask

  initial begin
    logic signed [31:0] periods [NPHASES];
    periods = '{vofd_pkg::LOG2TS_RESET, 32'sd0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                -32'sd167772160, 32'sd0};
    periods[5] = $urandom;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < NPHASES; p++) run_phase(p, periods[p]);
    wait_quiet();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // hold a while for stray results
    repeat (200) @(posedge clk);
    if (expected_diffs.size() != 0) begin
      $error("%0d results never arrived", expected_diffs.size());
      fail_count++;
    end
    $display("checked %0d results over %0d period settings and four idle/stall mixes",
             checked_count, NPHASES);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
